/* rtl/core/olar_pkg.sv */
package olar_pkg;

    // Store size and result limits.
    localparam int CAPACITY    = 16;
    localparam int MAX_RESULTS = 16;
    localparam int DUMP_MAX    = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;

    // Widths of the fields and of the internal counters.
    localparam int VALUE_W  = 32;
    localparam int MODE_W   = 2;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Operation codes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd2;

    // Status codes of a result word.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    // Commands broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic                      append;
        logic                      remove;
        logic                      rotate;
        logic signed [VALUE_W-1:0] value;
        logic [CNT_W-1:0]          count;
    } t_cell_ctl;

endpackage

/* rtl/core/olar_if.sv */
// Command channel: one word per operation.
interface olar_cmd_if;
    import olar_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink (input valid, input mode, input value, output ready);
endinterface

// Result channel: one or more words per operation.
interface olar_res_if;
    import olar_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] item_value;
    logic [COUNT_W-1:0]        count;
    logic [STATUS_W-1:0]       status;
    logic                      last;

    modport source (output valid, output item_value, output count, output status,
                    output last, input ready);
    modport sink (input valid, input item_value, input count, input status,
                  input last, output ready);
endinterface

/* rtl/core/olar_cell.sv */
module olar_cell (
    input  logic                              i_clk,
    input  olar_pkg::t_cell_ctl               i_ctl,
    input  logic [olar_pkg::IDX_W-1:0]        i_idx,
    input  logic                              i_prev_hit,
    input  logic signed [olar_pkg::VALUE_W-1:0] i_next_data,
    input  logic signed [olar_pkg::VALUE_W-1:0] i_head_data,
    output logic                              o_hit,
    output logic signed [olar_pkg::VALUE_W-1:0] o_data
);
    import olar_pkg::*;

    logic signed [VALUE_W-1:0] r_data;
    logic signed [VALUE_W-1:0] n_data;
    logic [CNT_W-1:0]          pos;
    logic                      occupied;
    logic                      is_tail;
    logic                      is_slot;

    // Position of this cell relative to the fill level.
    assign pos      = CNT_W'(i_idx);
    assign occupied = pos < i_ctl.count;
    assign is_tail  = pos == (i_ctl.count - CNT_W'(1));
    assign is_slot  = pos == i_ctl.count;

    // The first match anywhere at or before this cell marks it for a shift.
    assign o_hit  = i_prev_hit | (occupied && (r_data == i_ctl.value));
    assign o_data = r_data;

    // Append writes the free slot, remove closes the gap, dump rotates the row.
    always_comb begin
        n_data = r_data;
        if (i_ctl.append && is_slot) begin
            n_data = i_ctl.value;
        end else if (i_ctl.remove && o_hit) begin
            n_data = i_next_data;
        end else if (i_ctl.rotate) begin
            n_data = is_tail ? i_head_data : i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

/* rtl/core/olar_ctrl.sv */
module olar_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    olar_cmd_if.sink                            i_cmd,
    olar_res_if.source                          o_res,
    input  logic                                i_found,
    input  logic signed [olar_pkg::VALUE_W-1:0] i_head_data,
    output olar_pkg::t_cell_ctl                 o_ctl
);
    import olar_pkg::*;

    typedef enum logic {S_IDLE, S_DUMP} t_state;

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [CNT_W-1:0]          r_rot_left, n_rot_left;
    logic [CNT_W-1:0]          r_emit_left, n_emit_left;
    logic                      r_out_valid, n_out_valid;
    logic signed [VALUE_W-1:0] r_item, n_item;
    logic [STATUS_W-1:0]       r_status, n_status;
    logic                      r_last, n_last;
    logic [CNT_W-1:0]          r_out_count, n_out_count;

    logic out_free;
    logic accept;
    logic emitting;

    // The output register is free when empty or taken in this cycle.
    assign out_free    = !r_out_valid || o_res.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && out_free;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign emitting    = r_emit_left != '0;

    assign o_res.valid      = r_out_valid;
    assign o_res.item_value = r_item;
    assign o_res.count      = COUNT_W'(r_out_count);
    assign o_res.status     = r_status;
    assign o_res.last       = r_last;

    // Next-state logic for the sequencer and the result word.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rot_left   = r_rot_left;
        n_emit_left  = r_emit_left;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_item       = r_item;
        n_status     = r_status;
        n_last       = r_last;
        n_out_count  = r_out_count;
        o_ctl.append = 1'b0;
        o_ctl.remove = 1'b0;
        o_ctl.rotate = 1'b0;
        o_ctl.value  = i_cmd.value;
        o_ctl.count  = r_count;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_item   = '0;
                    n_status = ST_OK;
                    n_last   = 1'b1;
                    case (i_cmd.mode)
                        MODE_APPEND: begin
                            if (r_count >= CNT_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                o_ctl.append = 1'b1;
                                n_count      = r_count + CNT_W'(1);
                            end
                            n_out_valid = 1'b1;
                        end
                        MODE_REMOVE: begin
                            o_ctl.remove = 1'b1;
                            if (i_found) begin
                                n_count = r_count - CNT_W'(1);
                            end else begin
                                n_status = ST_NOT_FOUND;
                            end
                            n_out_valid = 1'b1;
                        end
                        MODE_DUMP: begin
                            if (r_count == '0) begin
                                n_status    = ST_EMPTY;
                                n_out_valid = 1'b1;
                            end else begin
                                n_state     = S_DUMP;
                                n_rot_left  = r_count;
                                n_emit_left = (r_count > CNT_W'(DUMP_MAX)) ?
                                              CNT_W'(DUMP_MAX) : r_count;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                    n_out_count = n_count;
                end
            end
            S_DUMP: begin
                // One rotation per step; a step that emits waits for the output.
                if (!emitting || out_free) begin
                    o_ctl.rotate = 1'b1;
                    n_rot_left   = r_rot_left - CNT_W'(1);
                    if (emitting) begin
                        n_out_valid = 1'b1;
                        n_item      = i_head_data;
                        n_status    = ST_OK;
                        n_last      = r_emit_left == CNT_W'(1);
                        n_out_count = r_count;
                        n_emit_left = r_emit_left - CNT_W'(1);
                    end
                    if (r_rot_left == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rot_left  <= '0;
            r_emit_left <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rot_left  <= n_rot_left;
            r_emit_left <= n_emit_left;
            r_out_valid <= n_out_valid;
        end
        r_item      <= n_item;
        r_status    <= n_status;
        r_last      <= n_last;
        r_out_count <= n_out_count;
    end

endmodule

/* rtl/core/ordered_list_append_remove.sv */
// Insertion-ordered list of signed 32-bit words held in a row of 16 cells.
// Command channel i_cmd carries mode and value; result channel o_res carries
// item_value, count, status and last, each word ending on valid and ready.
// Append writes the value into the first free cell and answers one word with
// the new count, or status full when all cells are taken. Remove compares all
// cells at once, shifts every cell behind the first match one place forward
// and answers one word, ok or not found. Both answer in the cycle after accept.
// Dump rotates the row one cell per cycle, held while the output register
// keeps an untaken word, and emits the head cell at each step, so a list
// of n entries gives n words, each loaded into the output register from
// the dump state, over n rotation steps paced by the output handshake;
// the last word has last set. An empty dump answers one word with status
// empty. A dump holds the command channel for the n rotation steps of the row.
// A stalled receiver holds the result word in the output register; the next
// command is taken in the cycle in which that word leaves.
// Reset (synchronous, active low) empties the list and drops any pending word.
module ordered_list_append_remove (
    input  logic       i_clk,
    input  logic       i_rst_n,
    olar_cmd_if.sink   i_cmd,
    olar_res_if.source o_res
);
    import olar_pkg::*;

    t_cell_ctl                 ctl;
    logic [CAPACITY-1:0]       hit;
    logic signed [VALUE_W-1:0] data [CAPACITY];
    logic                      found;

    assign found = hit[CAPACITY-1];

    // Sequencer and result register.
    olar_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_res       (o_res),
        .i_found     (found),
        .i_head_data (data[0]),
        .o_ctl       (ctl)
    );

    // Row of cells; each takes its neighbor's word on a shift or rotation.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                      prev_hit;
        logic signed [VALUE_W-1:0] next_data;

        if (g == 0) begin : g_head
            assign prev_hit = 1'b0;
        end else begin : g_body
            assign prev_hit = hit[g-1];
        end

        if (g == CAPACITY - 1) begin : g_end
            assign next_data = data[g];
        end else begin : g_mid
            assign next_data = data[g+1];
        end

        olar_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_idx       (IDX_W'(g)),
            .i_prev_hit  (prev_hit),
            .i_next_data (next_data),
            .i_head_data (data[0]),
            .o_hit       (hit[g]),
            .o_data      (data[g])
        );
    end

`ifndef SYNTHESIS
    // The fill level never passes the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // An accepted append with room grows the list by one.
    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid && i_cmd.ready && (i_cmd.mode == MODE_APPEND) &&
        (ctl.count < CNT_W'(CAPACITY))
        |=> ctl.count == $past(ctl.count) + CNT_W'(1))
        else $error("append did not grow the list");

    // A remove that misses leaves the fill level alone.
    a_miss_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid && i_cmd.ready && (i_cmd.mode == MODE_REMOVE) && !found
        |=> $stable(ctl.count))
        else $error("remove without match changed the list");

    // A pending result word always reports the current fill level.
    a_word_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.count == COUNT_W'(ctl.count))
        else $error("result word count differs from fill level");
`endif

endmodule

/* tb/olar_list_checker.sv */
// Watches both channels of the ordered list, keeps its own copy of the list,
// predicts every result word and compares the words that leave the block.
module olar_list_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    olar_cmd_if  cmd_mon,
    olar_res_if  res_mon,
    output int   o_err_count,
    output int   o_pending
);
    import olar_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [VALUE_W-1:0] item_value;
        logic [COUNT_W-1:0]        count;
        logic [STATUS_W-1:0]       status;
        logic                      last;
    } t_res_word;

    // Shadow copy of the list and the words it still owes.
    logic signed [VALUE_W-1:0] shadow_list [CAPACITY];
    int unsigned               held;
    t_res_word                 due_words [$];

    initial begin
        o_err_count = 0;
        o_pending   = 0;
        held        = 0;
    end

    task automatic push_word(input logic signed [VALUE_W-1:0] item,
                             input logic [STATUS_W-1:0] st, input logic is_last);
        t_res_word w;
        w.item_value = item;
        w.count      = COUNT_W'(held);
        w.status     = st;
        w.last       = is_last;
        due_words.push_back(w);
    endtask

    // Apply one accepted command to the shadow list and queue its words.
    task automatic apply_list_op(input logic [MODE_W-1:0] mode,
                                 input logic signed [VALUE_W-1:0] value);
        int unsigned idx;
        int unsigned n;
        case (mode)
            MODE_APPEND: begin
                if (held >= CAPACITY) begin
                    push_word('0, ST_FULL, 1'b1);
                end else begin
                    shadow_list[IDX_W'(held)] = value;
                    held++;
                    push_word('0, ST_OK, 1'b1);
                end
            end
            MODE_REMOVE: begin
                idx = 0;
                while (idx < held && shadow_list[IDX_W'(idx)] != value) idx++;
                if (idx >= held) begin
                    push_word('0, ST_NOT_FOUND, 1'b1);
                end else begin
                    // Close the gap so the order of the rest is kept.
                    for (int unsigned k = idx; k + 1 < held; k++)
                        shadow_list[IDX_W'(k)] = shadow_list[IDX_W'(k + 1)];
                    held--;
                    push_word('0, ST_OK, 1'b1);
                end
            end
            MODE_DUMP: begin
                if (held == 0) begin
                    push_word('0, ST_EMPTY, 1'b1);
                end else begin
                    n = (held > DUMP_MAX) ? DUMP_MAX : held;
                    for (int unsigned k = 0; k < n; k++)
                        push_word(shadow_list[IDX_W'(k)], ST_OK, (k + 1 == n));
                end
            end
            default: begin
                // The unused mode leaves the list alone and answers one word.
                push_word('0, ST_OK, 1'b1);
            end
        endcase
    endtask

    task automatic compare_word(input t_res_word want, input t_res_word got);
        if (got.item_value !== want.item_value) begin
            o_err_count++;
            $display("%0t: item_value mismatch, expected %0d, actual %0d",
                     $time, want.item_value, got.item_value);
        end
        if (got.count !== want.count) begin
            o_err_count++;
            $display("%0t: count mismatch, expected %0d, actual %0d",
                     $time, want.count, got.count);
        end
        if (got.status !== want.status) begin
            o_err_count++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
        end
        if (got.last !== want.last) begin
            o_err_count++;
            $display("%0t: last mismatch, expected %0d, actual %0d",
                     $time, want.last, got.last);
        end
    endtask

    // Sample both channels at the rising edge.
    always @(posedge i_clk) begin
        t_res_word got;
        t_res_word want;
        if (!i_rst_n) begin
            held = 0;
            due_words.delete();
        end else begin
            if (cmd_mon.valid && cmd_mon.ready)
                apply_list_op(cmd_mon.mode, cmd_mon.value);
            if (res_mon.valid && res_mon.ready) begin
                got.item_value = res_mon.item_value;
                got.count      = res_mon.count;
                got.status     = res_mon.status;
                got.last       = res_mon.last;
                if (due_words.size() == 0) begin
                    o_err_count++;
                    $display("%0t: unexpected word, expected none, actual %0d/%0d/%0d/%0d",
                             $time, got.item_value, got.count, got.status, got.last);
                end else begin
                    want = due_words.pop_front();
                    compare_word(want, got);
                end
            end
        end
        o_pending <= due_words.size();
    end

endmodule

/* tb/tb.sv */
// Drives commands into the ordered list under several idle patterns and
// reports the verdict from the checker's error count.
module tb;
    import olar_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int RAND_ITEMS_PER_PHASE = 50;

    logic clk;
    logic rst_n;
    int   err_count;
    int   pending;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   n_append;
    int   n_remove;
    int   n_dump;
    int   n_other;

    logic signed [VALUE_W-1:0] value_pool [8];

    olar_cmd_if cmd_ch ();
    olar_res_if res_ch ();

    ordered_list_append_remove uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_res   (res_ch.source)
    );

    olar_list_checker list_chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .cmd_mon     (cmd_ch),
        .res_mon     (res_ch),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    // 8 ns clock.
    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Receiver back-pressure, redrawn at every falling edge.
    always @(negedge clk) begin
        res_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Safety net against a hung handshake.
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Send one command word: random idle gap, then hold it until accepted.
    task automatic send_cmd(input logic [MODE_W-1:0] mode,
                            input logic signed [VALUE_W-1:0] value);
        logic taken;
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid = 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid = 1'b1;
        cmd_ch.mode  = mode;
        cmd_ch.value = value;
        taken = 1'b0;
        while (!taken) begin
            @(posedge clk);
            taken = cmd_ch.ready;
        end
        @(negedge clk);
        case (mode)
            MODE_APPEND: n_append++;
            MODE_REMOVE: n_remove++;
            MODE_DUMP:   n_dump++;
            default:     n_other++;
        endcase
    endtask

    // Random traffic that drifts between filling and draining the list.
    task automatic run_random_phase(input int items);
        logic filling;
        int   pick;
        logic [MODE_W-1:0] mode;
        logic signed [VALUE_W-1:0] value;
        filling = 1'($urandom_range(1));
        for (int i = 0; i < items; i++) begin
            if ($urandom_range(9) == 0) filling = !filling;
            pick = $urandom_range(99);
            if (pick < 3)
                mode = MODE_UNUSED;
            else if (pick < 15)
                mode = MODE_DUMP;
            else if (pick < (filling ? 75 : 40))
                mode = MODE_APPEND;
            else
                mode = MODE_REMOVE;
            // Mostly pool values so that removes find matches and duplicates.
            if ($urandom_range(3) == 0)
                value = $urandom();
            else
                value = value_pool[3'($urandom_range(7))];
            send_cmd(mode, value);
        end
    endtask

    initial begin
        cmd_ch.valid   = 1'b0;
        cmd_ch.mode    = MODE_APPEND;
        cmd_ch.value   = '0;
        res_ch.ready   = 1'b0;
        rst_n          = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        n_append       = 0;
        n_remove       = 0;
        n_dump         = 0;
        n_other        = 0;
        value_pool[0]  = 32'sh8000_0000;
        value_pool[1]  = 32'sh7fff_ffff;
        value_pool[2]  = '0;
        value_pool[3]  = -32'sd1;
        for (int i = 4; i < 8; i++) value_pool[3'(i)] = $urandom();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty cases, extremes, remove at head, middle and tail.
        send_cmd(MODE_DUMP, '0);
        send_cmd(MODE_REMOVE, 32'sd5);
        send_cmd(MODE_UNUSED, -32'sd1);
        send_cmd(MODE_APPEND, 32'sh8000_0000);
        send_cmd(MODE_APPEND, 32'sh7fff_ffff);
        send_cmd(MODE_APPEND, '0);
        send_cmd(MODE_APPEND, -32'sd1);
        send_cmd(MODE_APPEND, 32'sd1);
        send_cmd(MODE_DUMP, '0);
        send_cmd(MODE_REMOVE, '0);
        send_cmd(MODE_REMOVE, 32'sh8000_0000);
        send_cmd(MODE_REMOVE, 32'sd1);
        send_cmd(MODE_REMOVE, 32'sd5);
        send_cmd(MODE_APPEND, 32'sd2);
        send_cmd(MODE_DUMP, '0);
        // Fill to capacity with repeats, overflow once, then a full dump.
        for (int i = 0; i < CAPACITY - 3; i++)
            send_cmd(MODE_APPEND, value_pool[3'(i % 4)]);
        send_cmd(MODE_APPEND, 32'sd9);
        send_cmd(MODE_DUMP, '0);
        send_cmd(MODE_REMOVE, -32'sd1);

        // Random part under each idle pattern in turn.
        run_random_phase(RAND_ITEMS_PER_PHASE);
        send_idle_pct = 81;
        run_random_phase(RAND_ITEMS_PER_PHASE);
        send_idle_pct  = 0;
        recv_stall_pct = 81;
        run_random_phase(RAND_ITEMS_PER_PHASE);
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        run_random_phase(RAND_ITEMS_PER_PHASE);

        cmd_ch.valid = 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d appends, %0d removes, %0d dumps and %0d unused-mode words",
                 n_append, n_remove, n_dump, n_other);
        $display("under free-running, sender-idle, receiver-stall and light-idle traffic.");
        if (err_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
